FILE: hw/rtl/plal_pkg.sv
// Shared types and codes for the polyline arc-length lookup.
// No dependencies.
package plal_pkg;

	localparam logic [1:0] MODE_CLEAR  = 2'd0;
	localparam logic [1:0] MODE_APPEND = 2'd1;
	localparam logic [1:0] MODE_QUERY  = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_SHORT = 2'd2;
	localparam logic [1:0] ST_PAST  = 2'd3;

	// sum of three 50-bit squares
	localparam int SQ_W    = 52;
	localparam int ROOT_IT = SQ_W / 2;
	// quotient bits of the rounding divide
	localparam int QW      = 25;

	typedef struct packed {
		logic signed [23:0] x;
		logic signed [23:0] y;
		logic signed [23:0] z;
		logic [15:0]        speed;
		logic [3:0]         sector;
		logic [31:0]        run;
	} entry_t;

endpackage

FILE: hw/rtl/polyline_arc_length_lookup.sv
// Polyline arc-length lookup: waypoint store, segment length by iterative
// square root, binary search and interpolation by a serial divider.
// Depends on plal_pkg.
//
// Usage: drive mode and the payload with start high; the word is taken at
// the edge where start is high and busy is low. One result follows per word,
// shown for one cycle with done high; the receiver cannot stall it.
// The configuration channel (cfg_valid/cfg_ready/cfg_data) writes the brake
// threshold; it is always ready and should be used while busy is low.
// Steps from acceptance to done:
//   clear, unused mode, full store, short store, past end: done from idle
//   first append: store write only; later appends: 3 multiply steps, 26 root
//   steps, then the store write; query: a read and a compare per binary
//   search step (up to ceil(log2(n-1)) steps), then the last search read, the
//   two segment reads and setup, then per field (4) one multiply, one setup,
//   25 divide steps and one fix-up; a zero-length segment ends after setup.
// One word at a time.
// Reset clears the point count and threshold; store contents stay unset.
module polyline_arc_length_lookup #(
	parameter int MAX_POINTS = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         mode,
	input  logic signed [23:0] point_x,
	input  logic signed [23:0] point_y,
	input  logic signed [23:0] point_z,
	input  logic [15:0]        target_speed,
	input  logic [3:0]         sector_id,
	input  logic [31:0]        query_distance,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [7:0]         cfg_data,
	output logic               done,
	output logic signed [23:0] out_x,
	output logic signed [23:0] out_y,
	output logic signed [23:0] out_z,
	output logic [15:0]        out_speed,
	output logic [3:0]         out_sector,
	output logic [31:0]        line_length,
	output logic               braking_point,
	output logic [1:0]         status
);

	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int SQ_W = plal_pkg::SQ_W;
	localparam int QW = plal_pkg::QW;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SQ   = 4'd1;
	localparam logic [3:0] S_ROOT = 4'd2;
	localparam logic [3:0] S_APP  = 4'd3;
	localparam logic [3:0] S_SRCH = 4'd4;
	localparam logic [3:0] S_CMP  = 4'd5;
	localparam logic [3:0] S_RDA  = 4'd6;
	localparam logic [3:0] S_RDB  = 4'd7;
	localparam logic [3:0] S_SEG  = 4'd8;
	localparam logic [3:0] S_MUL  = 4'd9;
	localparam logic [3:0] S_DIV0 = 4'd10;
	localparam logic [3:0] S_DIV  = 4'd11;
	localparam logic [3:0] S_DIVF = 4'd12;

	logic [3:0] state_q;
	logic [7:0] thr_q;
	logic [CW-1:0] count_q;

	plal_pkg::entry_t mem [MAX_POINTS];
	plal_pkg::entry_t rdata_q;
	logic [AW-1:0] raddr;
	logic we;
	plal_pkg::entry_t wdata;

	plal_pkg::entry_t last_q, ea_q, eb_q;
	logic signed [23:0] px_q, py_q, pz_q;
	logic [15:0] ps_q;
	logic [3:0] psec_q;
	logic brk_q;
	logic [31:0] d_q;

	logic [1:0] k_q;
	logic [4:0] it_q;
	logic [SQ_W-1:0] acc_q, v_q, r_q, bit_q;

	logic [AW-1:0] lo_q, hi_q, mid_q, mid;
	logic [31:0] len_q, num_q;
	logic [56:0] prod_q;
	logic [32:0] rem_q;
	logic [QW-1:0] sh_q, quo_q;

	logic signed [23:0] ox_q, oy_q, oz_q;
	logic [15:0] osp_q;
	logic [3:0] osec_q;
	logic [31:0] olen_q;
	logic obrk_q, done_q;
	logic [1:0] ost_q;

	assign busy = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign done = done_q;
	assign out_x = ox_q;
	assign out_y = oy_q;
	assign out_z = oz_q;
	assign out_speed = osp_q;
	assign out_sector = osec_q;
	assign line_length = olen_q;
	assign braking_point = obrk_q;
	assign status = ost_q;

	assign mid = lo_q + ((hi_q - lo_q) >> 1);

	// braking test against the previous waypoint
	logic signed [16:0] sdiff;
	logic [23:0] brhs;
	logic brk_now;
	assign sdiff = $signed({1'b0, last_q.speed}) - $signed({1'b0, target_speed});
	assign brhs = thr_q * last_q.speed;
	assign brk_now = $signed({sdiff, 8'b0}) > $signed({1'b0, brhs});

	// squared segment components, one per cycle
	logic signed [24:0] dsel;
	logic signed [49:0] dsq;
	always_comb begin
		case (k_q)
			2'd0:    dsel = 25'(px_q) - 25'(last_q.x);
			2'd1:    dsel = 25'(py_q) - 25'(last_q.y);
			default: dsel = 25'(pz_q) - 25'(last_q.z);
		endcase
	end
	assign dsq = dsel * dsel;

	logic [SQ_W-1:0] rb;
	assign rb = r_q + bit_q;

	// interpolation operands for the field in turn
	logic signed [24:0] fa, fb;
	always_comb begin
		case (k_q)
			2'd0:    begin fa = 25'(ea_q.x); fb = 25'(eb_q.x); end
			2'd1:    begin fa = 25'(ea_q.y); fb = 25'(eb_q.y); end
			2'd2:    begin fa = 25'(ea_q.z); fb = 25'(eb_q.z); end
			default: begin fa = {9'b0, ea_q.speed}; fb = {9'b0, eb_q.speed}; end
		endcase
	end
	logic signed [25:0] fd;
	logic [24:0] fmag;
	logic [56:0] fprod;
	logic [57:0] nval;
	logic [33:0] dtrial;
	logic [33:0] dden;
	logic signed [24:0] fres;
	assign fd = 26'(fb) - 26'(fa);
	assign fmag = fd[25] ? 25'(-fd) : fd[24:0];
	assign fprod = fmag * num_q;
	assign nval = {prod_q, 1'b0} + {26'b0, len_q};
	assign dden = {1'b0, len_q, 1'b0};
	assign dtrial = {rem_q, sh_q[QW-1]};
	assign fres = fd[25] ? fa - $signed(quo_q) : fa + $signed(quo_q);

	logic [32:0] runsum;
	assign runsum = {1'b0, last_q.run} + {1'b0, r_q[31:0]};

	logic [31:0] seglen, segnum;
	assign seglen = eb_q.run - ea_q.run;
	assign segnum = (d_q > ea_q.run) ? d_q - ea_q.run : 32'd0;

	always_comb begin
		raddr = mid;
		case (state_q)
			S_SRCH:  raddr = (lo_q < hi_q) ? mid : lo_q - AW'(1);
			S_RDA:   raddr = lo_q;
			default: raddr = mid;
		endcase
	end

	always_comb begin
		we = 1'b0;
		wdata = '{x: px_q, y: py_q, z: pz_q, speed: ps_q, sector: psec_q,
			run: runsum[32] ? 32'hFFFF_FFFF : runsum[31:0]};
		if (state_q == S_APP)
			we = 1'b1;
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[count_q[AW-1:0]] <= wdata;
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			thr_q <= 8'd0;
			count_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid)
				thr_q <= cfg_data;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						ox_q <= '0; oy_q <= '0; oz_q <= '0; osp_q <= '0;
						osec_q <= '0; obrk_q <= 1'b0; ost_q <= plal_pkg::ST_OK;
						olen_q <= (count_q == '0) ? 32'd0 : last_q.run;
						px_q <= point_x; py_q <= point_y; pz_q <= point_z;
						ps_q <= target_speed; psec_q <= sector_id;
						d_q <= query_distance;
						case (mode)
							plal_pkg::MODE_CLEAR: begin
								count_q <= '0;
								olen_q <= 32'd0;
								done_q <= 1'b1;
							end
							plal_pkg::MODE_APPEND: begin
								if (count_q >= CW'(MAX_POINTS)) begin
									ost_q <= plal_pkg::ST_FULL;
									done_q <= 1'b1;
								end else if (count_q == '0) begin
									// first point: no segment, run length zero
									r_q <= '0;
									last_q.run <= 32'd0;
									brk_q <= 1'b0;
									state_q <= S_APP;
								end else begin
									brk_q <= brk_now;
									acc_q <= '0;
									k_q <= 2'd0;
									state_q <= S_SQ;
								end
							end
							plal_pkg::MODE_QUERY: begin
								if (count_q < CW'(2)) begin
									ost_q <= plal_pkg::ST_SHORT;
									done_q <= 1'b1;
								end else if (last_q.run < query_distance) begin
									ox_q <= last_q.x; oy_q <= last_q.y; oz_q <= last_q.z;
									osp_q <= last_q.speed; osec_q <= last_q.sector;
									ost_q <= plal_pkg::ST_PAST;
									done_q <= 1'b1;
								end else begin
									lo_q <= AW'(1);
									hi_q <= AW'(count_q - CW'(1));
									state_q <= S_SRCH;
								end
							end
							default: done_q <= 1'b1;
						endcase
					end
				end
				S_SQ: begin
					acc_q <= acc_q + SQ_W'(unsigned'(dsq));
					k_q <= k_q + 2'd1;
					if (k_q == 2'd2) begin
						v_q <= acc_q + SQ_W'(unsigned'(dsq));
						r_q <= '0;
						bit_q <= SQ_W'(1) << (SQ_W - 2);
						it_q <= '0;
						state_q <= S_ROOT;
					end
				end
				S_ROOT: begin
					if (v_q >= rb) begin
						v_q <= v_q - rb;
						r_q <= (r_q >> 1) + bit_q;
					end else begin
						r_q <= r_q >> 1;
					end
					bit_q <= bit_q >> 2;
					it_q <= it_q + 5'd1;
					if (it_q == 5'(plal_pkg::ROOT_IT - 1))
						state_q <= S_APP;
				end
				S_APP: begin
					last_q <= wdata;
					count_q <= count_q + CW'(1);
					ox_q <= px_q; oy_q <= py_q; oz_q <= pz_q;
					osp_q <= ps_q; osec_q <= psec_q;
					olen_q <= wdata.run;
					obrk_q <= brk_q;
					done_q <= 1'b1;
					state_q <= S_IDLE;
				end
				S_SRCH: begin
					mid_q <= mid;
					state_q <= (lo_q < hi_q) ? S_CMP : S_RDA;
				end
				S_CMP: begin
					if (rdata_q.run >= d_q)
						hi_q <= mid_q;
					else
						lo_q <= mid_q + AW'(1);
					state_q <= S_SRCH;
				end
				S_RDA: begin
					ea_q <= rdata_q;
					state_q <= S_RDB;
				end
				S_RDB: begin
					eb_q <= rdata_q;
					state_q <= S_SEG;
				end
				S_SEG: begin
					osec_q <= eb_q.sector;
					len_q <= seglen;
					num_q <= (segnum > seglen) ? seglen : segnum;
					k_q <= 2'd0;
					if (seglen == 32'd0) begin
						// degenerate segment gives its start point, with the end point's sector
						ox_q <= ea_q.x; oy_q <= ea_q.y; oz_q <= ea_q.z;
						osp_q <= ea_q.speed;
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					prod_q <= fprod;
					state_q <= S_DIV0;
				end
				S_DIV0: begin
					rem_q <= nval[57:QW];
					sh_q <= nval[QW-1:0];
					quo_q <= '0;
					it_q <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (dtrial >= dden) begin
						rem_q <= 33'(dtrial - dden);
						quo_q <= {quo_q[QW-2:0], 1'b1};
					end else begin
						rem_q <= dtrial[32:0];
						quo_q <= {quo_q[QW-2:0], 1'b0};
					end
					sh_q <= sh_q << 1;
					it_q <= it_q + 5'd1;
					if (it_q == 5'(QW - 1))
						state_q <= S_DIVF;
				end
				S_DIVF: begin
					case (k_q)
						2'd0:    ox_q <= fres[23:0];
						2'd1:    oy_q <= fres[23:0];
						2'd2:    oz_q <= fres[23:0];
						default: osp_q <= fres[15:0];
					endcase
					k_q <= k_q + 2'd1;
					if (k_q == 2'd3) begin
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_MUL;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
